FILE: hw/rtl/digital_clock_with_scanned_display_macros.svh
// Assertion macros shared by the checker file of the digital clock block.
// Depends on nothing; included by bare file name.
`ifndef DIGITAL_CLOCK_WITH_SCANNED_DISPLAY_MACROS_SVH
`define DIGITAL_CLOCK_WITH_SCANNED_DISPLAY_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DCSD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define DCSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also checks across reset.
`define DCSD_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/dcsd_pkg.sv
// Package of the digital clock block: widths, reset values, register map,
// shared structs and the seven-segment helper functions. Depends on nothing.
package dcsd_pkg;

  localparam int TICK_W    = 10;
  localparam int DEB_W     = 8;
  localparam int HOLD_W    = 10;
  localparam int REP_W     = 8;
  localparam int TIMER_W   = 10;
  localparam int HOUR_W    = 5;
  localparam int MIN_W     = 6;
  localparam int SEC_W     = 6;
  localparam int SEG_W     = 8;
  localparam int SEL_W     = 8;
  localparam int SCAN_W    = 3;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int DIGIT_COUNT_DEF = 8;

  localparam logic [TICK_W-1:0] TPS_RST  = 10'd500;
  localparam logic [DEB_W-1:0]  DEB_RST  = 8'd5;
  localparam logic [HOLD_W-1:0] HOLD_RST = 10'd500;
  localparam logic [REP_W-1:0]  REP_RST  = 8'd25;

  localparam logic [HOUR_W-1:0] HOUR_MAX = 5'd23;
  localparam logic [MIN_W-1:0]  MIN_MAX  = 6'd59;
  localparam logic [SEC_W-1:0]  SEC_MAX  = 6'd59;

  // Register index, taken from paddr[3:2].
  localparam logic [1:0] REG_TPS  = 2'd0;
  localparam logic [1:0] REG_DEB  = 2'd1;
  localparam logic [1:0] REG_HOLD = 2'd2;
  localparam logic [1:0] REG_REP  = 2'd3;

  localparam logic OWNER_HOUR   = 1'b0;
  localparam logic OWNER_MINUTE = 1'b1;

  localparam logic [SEG_W-1:0] SEG_DASH = 8'h40;
  localparam logic [SEG_W-1:0] SEG_TABLE [10] = '{
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
  };

  typedef struct packed {
    logic [TICK_W-1:0] ticks_per_second;
    logic [DEB_W-1:0]  debounce_ticks;
    logic [HOLD_W-1:0] hold_ticks;
    logic [REP_W-1:0]  repeat_ticks;
  } cfg_t;

  typedef struct packed {
    logic bump;
    logic owner;
  } bump_req_t;

  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
  } time_t;

  // Tens digit of a value below 64.
  function automatic logic [2:0] tens_of(input logic [5:0] v);
    logic [2:0] t;
    if (v >= 6'd60)      t = 3'd6;
    else if (v >= 6'd50) t = 3'd5;
    else if (v >= 6'd40) t = 3'd4;
    else if (v >= 6'd30) t = 3'd3;
    else if (v >= 6'd20) t = 3'd2;
    else if (v >= 6'd10) t = 3'd1;
    else                 t = 3'd0;
    return t;
  endfunction

  function automatic logic [3:0] ones_of(input logic [5:0] v);
    logic [5:0] r;
    r = v - 6'(6'(tens_of(v)) * 6'd10);
    return r[3:0];
  endfunction

  function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    if (d <= 4'd9) s = SEG_TABLE[d];
    else           s = SEG_TABLE[0];
    return s;
  endfunction

endpackage

FILE: hw/rtl/dcsd_if.sv
// Valid/ready channel interfaces of the digital clock: tick words in,
// display words out. Depends on dcsd_pkg.
interface dcsd_in_if;
  logic valid;
  logic ready;
  logic hour_key_level;
  logic minute_key_level;

  modport source (output valid, output hour_key_level, output minute_key_level,
                  input ready);
  modport sink   (input valid, input hour_key_level, input minute_key_level,
                  output ready);
endinterface

interface dcsd_out_if;
  logic                        valid;
  logic                        ready;
  logic [dcsd_pkg::SEG_W-1:0]  segment_pattern;
  logic [dcsd_pkg::SEL_W-1:0]  digit_select;
  logic [dcsd_pkg::HOUR_W-1:0] hour_value;
  logic [dcsd_pkg::MIN_W-1:0]  minute_value;
  logic [dcsd_pkg::SEC_W-1:0]  second_value;

  modport source (output valid, output segment_pattern, output digit_select,
                  output hour_value, output minute_value, output second_value,
                  input ready);
  modport sink   (input valid, input segment_pattern, input digit_select,
                  input hour_value, input minute_value, input second_value,
                  output ready);
endinterface

FILE: hw/rtl/digital_clock_with_scanned_display.sv
// Channel     | Dir | Handshake            | Word
// in_ch       | in  | valid/ready          | hour_key_level, minute_key_level
// out_ch      | out | valid/ready          | segments, digit select, h/m/s
// cfg (APB)   | in  | psel/penable/pready  | four timing registers
//
// One tick word per cycle while the output is not stalled: an input register feeds
// the clock, button and scan logic, which settle combinationally into the output
// register. A stalled output holds its word while one more tick waits in the input
// register, and ready drops only when both are full. Reset is synchronous and active
// low; it clears the valid flags and state registers, but not the data registers.
// Depends on dcsd_pkg, dcsd_if and the dcsd_* submodules.
module digital_clock_with_scanned_display #(
  parameter int DIGIT_COUNT = dcsd_pkg::DIGIT_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  dcsd_in_if.sink                      in_ch,
  dcsd_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dcsd_pkg::PADDR_W-1:0] paddr,
  input  logic [dcsd_pkg::PDATA_W-1:0] pwdata,
  output logic [dcsd_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import dcsd_pkg::*;

  cfg_t      cfg;
  bump_req_t bump_req;
  time_t     time_nxt, time_out;

  logic in_valid_r, in_valid_nxt;
  logic in_hour_r, in_min_r;
  logic out_valid_r, out_valid_nxt;
  logic out_free, advance, in_fire;

  assign out_free      = !out_valid_r || out_ch.ready;
  assign advance       = in_valid_r && out_free;
  assign in_ch.ready   = !in_valid_r || advance;
  assign in_fire       = in_ch.valid && in_ch.ready;
  assign in_valid_nxt  = in_fire ? 1'b1 : (advance ? 1'b0 : in_valid_r);
  assign out_valid_nxt = advance ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_hour_r <= in_ch.hour_key_level;
      in_min_r  <= in_ch.minute_key_level;
    end
  end

  dcsd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dcsd_keys u_keys (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (advance),
    .hour_key_level   (in_hour_r),
    .minute_key_level (in_min_r),
    .cfg              (cfg),
    .bump_req         (bump_req)
  );

  dcsd_time u_time (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .cfg      (cfg),
    .bump_req (bump_req),
    .time_nxt (time_nxt)
  );

  dcsd_display #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_display (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (advance),
    .time_in         (time_nxt),
    .segment_pattern (out_ch.segment_pattern),
    .digit_select    (out_ch.digit_select),
    .time_out        (time_out)
  );

  assign out_ch.valid        = out_valid_r;
  assign out_ch.hour_value   = time_out.hour;
  assign out_ch.minute_value = time_out.minute;
  assign out_ch.second_value = time_out.second;

endmodule

FILE: hw/rtl/dcsd_cfg_regs.sv
// APB-style configuration registers of the digital clock.
// Depends on dcsd_pkg.
module dcsd_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dcsd_pkg::PADDR_W-1:0] paddr,
  input  logic [dcsd_pkg::PDATA_W-1:0] pwdata,
  output logic [dcsd_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output dcsd_pkg::cfg_t               cfg
);
  import dcsd_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ticks_per_second <= TPS_RST;
      cfg_r.debounce_ticks   <= DEB_RST;
      cfg_r.hold_ticks       <= HOLD_RST;
      cfg_r.repeat_ticks     <= REP_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TPS:  cfg_r.ticks_per_second <= pwdata[TICK_W-1:0];
        REG_DEB:  cfg_r.debounce_ticks   <= pwdata[DEB_W-1:0];
        REG_HOLD: cfg_r.hold_ticks       <= pwdata[HOLD_W-1:0];
        REG_REP:  cfg_r.repeat_ticks     <= pwdata[REP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TPS:  prdata = PDATA_W'(cfg_r.ticks_per_second);
      REG_DEB:  prdata = PDATA_W'(cfg_r.debounce_ticks);
      REG_HOLD: prdata = PDATA_W'(cfg_r.hold_ticks);
      REG_REP:  prdata = PDATA_W'(cfg_r.repeat_ticks);
      default:  prdata = '0;
    endcase
  end

endmodule

FILE: hw/rtl/dcsd_keys.sv
// Set-button handler: debounce, hold, auto-repeat and release increment.
// Depends on dcsd_pkg.
module dcsd_keys (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic                 hour_key_level,
  input  logic                 minute_key_level,
  input  dcsd_pkg::cfg_t       cfg,
  output dcsd_pkg::bump_req_t  bump_req
);
  import dcsd_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE, PH_DEBOUNCE, PH_HELD, PH_REPEAT
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic               owner_r, owner_nxt;
  logic [TIMER_W-1:0] timer_r, timer_nxt;
  logic [TIMER_W-1:0] timer_inc;
  logic               hour_down, min_down, owner_down, bump;

  assign hour_down  = !hour_key_level;
  assign min_down   = !minute_key_level;
  assign owner_down = (owner_r == OWNER_HOUR) ? hour_down : min_down;
  assign timer_inc  = timer_r + TIMER_W'(1);

  always_comb begin
    phase_nxt = phase_r;
    owner_nxt = owner_r;
    timer_nxt = timer_r;
    bump      = 1'b0;
    unique case (phase_r)
      PH_IDLE: begin
        if (hour_down || min_down) begin
          owner_nxt = hour_down ? OWNER_HOUR : OWNER_MINUTE;
          phase_nxt = PH_DEBOUNCE;
          timer_nxt = '0;
        end
      end
      PH_DEBOUNCE: begin
        if (!owner_down) begin
          phase_nxt = PH_IDLE;
          timer_nxt = '0;
        end else if (timer_r >= TIMER_W'(cfg.debounce_ticks)) begin
          phase_nxt = PH_HELD;
          timer_nxt = '0;
        end else begin
          timer_nxt = timer_inc;
        end
      end
      PH_HELD: begin
        if (!owner_down) begin
          bump      = 1'b1;
          phase_nxt = PH_IDLE;
          timer_nxt = '0;
        end else if (timer_inc >= cfg.hold_ticks) begin
          bump      = 1'b1;
          phase_nxt = PH_REPEAT;
          timer_nxt = '0;
        end else begin
          timer_nxt = timer_inc;
        end
      end
      PH_REPEAT: begin
        if (!owner_down) begin
          bump      = 1'b1;
          phase_nxt = PH_IDLE;
          timer_nxt = '0;
        end else if (timer_inc >= TIMER_W'(cfg.repeat_ticks)) begin
          bump      = 1'b1;
          timer_nxt = '0;
        end else begin
          timer_nxt = timer_inc;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        timer_nxt = '0;
      end
    endcase
  end

  assign bump_req.bump  = step && bump;
  assign bump_req.owner = owner_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      owner_r <= OWNER_HOUR;
      timer_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      owner_r <= owner_nxt;
      timer_r <= timer_nxt;
    end
  end

endmodule

FILE: hw/rtl/dcsd_time.sv
// Timekeeping counters: tick prescaler, seconds, minutes and hours with
// carries, plus wrap-only set increments. Depends on dcsd_pkg.
module dcsd_time (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  dcsd_pkg::cfg_t      cfg,
  input  dcsd_pkg::bump_req_t bump_req,
  output dcsd_pkg::time_t     time_nxt
);
  import dcsd_pkg::*;

  logic [TICK_W-1:0] tick_r, tick_inc, tick_nxt;
  time_t             time_r, carried;
  logic              sec_tick, min_carry, hour_carry;

  assign tick_inc   = tick_r + TICK_W'(1);
  assign sec_tick   = tick_inc >= cfg.ticks_per_second;
  assign tick_nxt   = sec_tick ? '0 : tick_inc;
  assign min_carry  = sec_tick && (time_r.second >= SEC_MAX);
  assign hour_carry = min_carry && (time_r.minute >= MIN_MAX);

  always_comb begin
    carried = time_r;
    if (sec_tick) begin
      carried.second = min_carry ? '0 : time_r.second + SEC_W'(1);
    end
    if (min_carry) begin
      carried.minute = hour_carry ? '0 : time_r.minute + MIN_W'(1);
    end
    if (hour_carry) begin
      carried.hour = (time_r.hour >= HOUR_MAX) ? '0 : time_r.hour + HOUR_W'(1);
    end

    // A set increment lands on the carried time and never carries onward.
    time_nxt = carried;
    if (bump_req.bump) begin
      if (bump_req.owner == OWNER_HOUR) begin
        time_nxt.hour = (carried.hour >= HOUR_MAX) ? '0 : carried.hour + HOUR_W'(1);
      end else begin
        time_nxt.minute = (carried.minute >= MIN_MAX) ? '0 : carried.minute + MIN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
      time_r <= '0;
    end else if (step) begin
      tick_r <= tick_nxt;
      time_r <= time_nxt;
    end
  end

endmodule

FILE: hw/rtl/dcsd_display.sv
// Display scanner and result register: picks the scanned position, encodes
// its segments and holds the output word. Depends on dcsd_pkg.
module dcsd_display #(
  parameter int DIGIT_COUNT = dcsd_pkg::DIGIT_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  dcsd_pkg::time_t             time_in,
  output logic [dcsd_pkg::SEG_W-1:0]  segment_pattern,
  output logic [dcsd_pkg::SEL_W-1:0]  digit_select,
  output dcsd_pkg::time_t             time_out
);
  import dcsd_pkg::*;

  localparam logic [SCAN_W-1:0] POS_HOUR_TENS = 3'd0;
  localparam logic [SCAN_W-1:0] POS_HOUR_ONES = 3'd1;
  localparam logic [SCAN_W-1:0] POS_MIN_TENS  = 3'd3;
  localparam logic [SCAN_W-1:0] POS_MIN_ONES  = 3'd4;
  localparam logic [SCAN_W-1:0] POS_SEC_TENS  = 3'd6;
  localparam logic [SCAN_W-1:0] POS_SEC_ONES  = 3'd7;

  logic [SCAN_W-1:0] scan_r, scan_nxt;
  logic [SCAN_W:0]   scan_inc;
  logic [5:0]        hour_ext;
  logic [SEG_W-1:0]  seg_nxt;
  logic [SEL_W-1:0]  sel_nxt;
  logic [SEG_W-1:0]  seg_r;
  logic [SEL_W-1:0]  sel_r;
  time_t             time_r;

  assign hour_ext = 6'(time_in.hour);
  assign scan_inc = {1'b0, scan_r} + (SCAN_W+1)'(1);
  assign scan_nxt = (scan_inc >= (SCAN_W+1)'(DIGIT_COUNT)) ? '0 : scan_inc[SCAN_W-1:0];
  assign sel_nxt  = ~(SEL_W'(1) << scan_r);

  always_comb begin
    unique case (scan_r)
      POS_HOUR_TENS: seg_nxt = seg_of(4'(tens_of(hour_ext)));
      POS_HOUR_ONES: seg_nxt = seg_of(ones_of(hour_ext));
      POS_MIN_TENS:  seg_nxt = seg_of(4'(tens_of(time_in.minute)));
      POS_MIN_ONES:  seg_nxt = seg_of(ones_of(time_in.minute));
      POS_SEC_TENS:  seg_nxt = seg_of(4'(tens_of(time_in.second)));
      POS_SEC_ONES:  seg_nxt = seg_of(ones_of(time_in.second));
      default:       seg_nxt = SEG_DASH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= '0;
    end else if (load) begin
      scan_r <= scan_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      seg_r  <= seg_nxt;
      sel_r  <= sel_nxt;
      time_r <= time_in;
    end
  end

  assign segment_pattern = seg_r;
  assign digit_select    = sel_r;
  assign time_out        = time_r;

endmodule

FILE: hw/rtl/dcsd_checker.sv
// Port-level checker for the digital clock, attached by bind.
// Depends on dcsd_pkg and the assertion macro header.
`include "digital_clock_with_scanned_display_macros.svh"

module dcsd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [dcsd_pkg::SEL_W-1:0]  out_digit_select,
  input logic [dcsd_pkg::HOUR_W-1:0] out_hour_value,
  input logic [dcsd_pkg::MIN_W-1:0]  out_minute_value,
  input logic [dcsd_pkg::SEC_W-1:0]  out_second_value
);
  import dcsd_pkg::*;

  logic out_stalled;
  logic sel_one_hot;
  logic time_in_range;

  assign out_stalled   = out_valid && !out_ready;
  assign sel_one_hot   = $onehot(~out_digit_select);
  assign time_in_range = (out_hour_value <= HOUR_MAX) && (out_minute_value <= MIN_MAX) &&
                         (out_second_value <= SEC_MAX);

  `DCSD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stalled, out_valid, "word dropped while stalled")
  `DCSD_ASSERT_NOW(a_one_digit, clk, rst_n, out_valid, sel_one_hot, "select not one-hot low")
  `DCSD_ASSERT_NOW(a_time_range, clk, rst_n, out_valid, time_in_range, "time out of range")
  `DCSD_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid, "result valid right after reset")

endmodule

bind digital_clock_with_scanned_display dcsd_checker u_dcsd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_digit_select (out_ch.digit_select),
  .out_hour_value   (out_ch.hour_value),
  .out_minute_value (out_ch.minute_value),
  .out_second_value (out_ch.second_value)
);
